@@ rtl/core/mbet_pkg.sv @@
// Shared types and constants for the Mandelbrot escape-time block.
package mbet_pkg;

   localparam int unsigned COORD_WIDTH = 32;
   localparam int unsigned STEP_WIDTH = 31;
   localparam int unsigned INDEX_WIDTH = 12;
   localparam int unsigned COUNT_WIDTH = 16;
   localparam int unsigned PRODUCT_WIDTH = 2 * COORD_WIDTH;
   localparam int unsigned FRACTION_BITS = 28;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_X_ORIGIN = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_Y_ORIGIN = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_X_STEP = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_Y_STEP = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ITER_LIMIT = 3'd4;

   localparam logic signed [COORD_WIDTH-1:0] X_ORIGIN_RESET = -32'sd469762048;
   localparam logic signed [COORD_WIDTH-1:0] Y_ORIGIN_RESET = -32'sd335544320;
   localparam logic [STEP_WIDTH-1:0] X_STEP_RESET = 31'd163840;
   localparam logic [STEP_WIDTH-1:0] Y_STEP_RESET = 31'd163840;
   localparam logic [COUNT_WIDTH-1:0] ITER_LIMIT_RESET = 16'd500;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x_origin;
      logic signed [COORD_WIDTH-1:0] y_origin;
      logic [STEP_WIDTH-1:0]         x_step;
      logic [STEP_WIDTH-1:0]         y_step;
      logic [COUNT_WIDTH-1:0]        iteration_limit;
   } cfg_type;

   typedef struct packed {
      logic                   valid;
      logic [COUNT_WIDTH-1:0] count;
   } result_type;

endpackage

@@ rtl/core/mbet_mul.sv @@
// Shared signed multiplier with a registered product.
module mbet_mul (
   input  logic                                     clock,
   input  logic signed [mbet_pkg::COORD_WIDTH-1:0]   operand_a,
   input  logic signed [mbet_pkg::COORD_WIDTH-1:0]   operand_b,
   output logic signed [mbet_pkg::PRODUCT_WIDTH-1:0] product_ff
);
   import mbet_pkg::*;

   logic signed [PRODUCT_WIDTH-1:0] product_in;

   assign product_in = operand_a * operand_b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

@@ rtl/core/mbet_core.sv @@
// Sequencer: maps a pixel to c and runs the escape-time loop on the shared multiplier.
module mbet_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [mbet_pkg::INDEX_WIDTH-1:0]     column,
   input  logic [mbet_pkg::INDEX_WIDTH-1:0]     row,
   input  mbet_pkg::cfg_type                    cfg,
   input  logic                                 result_take,
   output logic                                 busy,
   output mbet_pkg::result_type                 result
);
   import mbet_pkg::*;

   localparam int unsigned ESC_SHIFT = 2 * FRACTION_BITS + 2;
   localparam bit ESC_ON = (ESC_SHIFT < PRODUCT_WIDTH);
   localparam logic [PRODUCT_WIDTH-1:0] ESC_LIMIT =
      ESC_ON ? (64'd1 << ESC_SHIFT) : '0;
   localparam logic signed [PRODUCT_WIDTH-1:0] SAT_HIGH = 64'sd2147483647;
   localparam logic signed [PRODUCT_WIDTH-1:0] SAT_LOW = -64'sd2147483648;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_CX,
      ST_MUL_CY,
      ST_INIT,
      ST_MUL_RR,
      ST_MUL_II,
      ST_MUL_RI,
      ST_UPDATE,
      ST_DONE
   } state_type;

   function automatic logic signed [COORD_WIDTH-1:0] sat32(
      input logic signed [PRODUCT_WIDTH-1:0] v
   );
      logic signed [COORD_WIDTH-1:0] r;
      if (v > SAT_HIGH) begin
         r = SAT_HIGH[COORD_WIDTH-1:0];
      end else if (v < SAT_LOW) begin
         r = SAT_LOW[COORD_WIDTH-1:0];
      end else begin
         r = v[COORD_WIDTH-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [PRODUCT_WIDTH-1:0] sext(
      input logic signed [COORD_WIDTH-1:0] v
   );
      return {{(PRODUCT_WIDTH-COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
   endfunction

   state_type                       state_ff;
   logic                            check_ff;
   logic [COUNT_WIDTH-1:0]          count_ff;
   logic [INDEX_WIDTH-1:0]          column_ff;
   logic [INDEX_WIDTH-1:0]          row_ff;
   logic signed [COORD_WIDTH-1:0]   cr_ff;
   logic signed [COORD_WIDTH-1:0]   ci_ff;
   logic signed [COORD_WIDTH-1:0]   zr_ff;
   logic signed [COORD_WIDTH-1:0]   zi_ff;
   logic signed [PRODUCT_WIDTH-1:0] rr_ff;
   logic signed [PRODUCT_WIDTH-1:0] ii_ff;

   logic signed [COORD_WIDTH-1:0]   operand_a;
   logic signed [COORD_WIDTH-1:0]   operand_b;
   logic signed [PRODUCT_WIDTH-1:0] product_ff;

   logic signed [COORD_WIDTH-1:0]   cr_in;
   logic signed [COORD_WIDTH-1:0]   ci_in;
   logic signed [PRODUCT_WIDTH-1:0] diff;
   logic signed [COORD_WIDTH-1:0]   zr_in;
   logic signed [COORD_WIDTH-1:0]   zi_in;
   logic [PRODUCT_WIDTH-1:0]        magnitude;
   logic                            escaped;
   logic [COUNT_WIDTH:0]            count_next;
   logic                            at_limit;

   mbet_mul u_mul (
      .clock      (clock),
      .operand_a  (operand_a),
      .operand_b  (operand_b),
      .product_ff (product_ff)
   );

   // Operand select for the shared multiplier
   always_comb begin
      case (state_ff)
         ST_MUL_CX: begin
            operand_a = {{(COORD_WIDTH-INDEX_WIDTH){1'b0}}, column_ff};
            operand_b = {{(COORD_WIDTH-STEP_WIDTH){1'b0}}, cfg.x_step};
         end
         ST_MUL_CY: begin
            operand_a = {{(COORD_WIDTH-INDEX_WIDTH){1'b0}}, row_ff};
            operand_b = {{(COORD_WIDTH-STEP_WIDTH){1'b0}}, cfg.y_step};
         end
         ST_MUL_RR: begin
            operand_a = zr_ff;
            operand_b = zr_ff;
         end
         ST_MUL_II: begin
            operand_a = zi_ff;
            operand_b = zi_ff;
         end
         default: begin
            operand_a = zr_ff;
            operand_b = zi_ff;
         end
      endcase
   end

   // c and the z update; product_ff holds the result issued one state earlier
   assign cr_in = sat32(sext(cfg.x_origin) + product_ff);
   assign ci_in = sat32(sext(cfg.y_origin) + product_ff);
   assign diff = rr_ff - ii_ff;
   assign zr_in = sat32((diff >>> FRACTION_BITS) + sext(cr_ff));
   assign zi_in = sat32((product_ff >>> (FRACTION_BITS - 1)) + sext(ci_ff));

   assign magnitude = $unsigned(rr_ff) + $unsigned(product_ff);
   assign escaped = ESC_ON && (magnitude >= ESC_LIMIT);
   assign count_next = {1'b0, count_ff} + {{COUNT_WIDTH{1'b0}}, 1'b1};
   assign at_limit = (count_next == {1'b0, cfg.iteration_limit});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         check_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  column_ff <= column;
                  row_ff <= row;
                  state_ff <= ST_MUL_CX;
               end
            end
            ST_MUL_CX: begin
               state_ff <= ST_MUL_CY;
            end
            ST_MUL_CY: begin
               cr_ff <= cr_in;
               state_ff <= ST_INIT;
            end
            ST_INIT: begin
               ci_ff <= ci_in;
               zr_ff <= cr_ff;
               zi_ff <= ci_in;
               count_ff <= '0;
               check_ff <= 1'b0;
               if (cfg.iteration_limit == '0) begin
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_MUL_RR;
               end
            end
            ST_MUL_RR: begin
               state_ff <= ST_MUL_II;
            end
            ST_MUL_II: begin
               rr_ff <= product_ff;
               state_ff <= ST_MUL_RI;
            end
            ST_MUL_RI: begin
               ii_ff <= product_ff;
               // test the z left by the previous update
               if (check_ff) begin
                  if (escaped) begin
                     state_ff <= ST_DONE;
                  end else begin
                     count_ff <= count_next[COUNT_WIDTH-1:0];
                     if (at_limit) begin
                        state_ff <= ST_DONE;
                     end else begin
                        state_ff <= ST_UPDATE;
                     end
                  end
               end else begin
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               zr_ff <= zr_in;
               zi_ff <= zi_in;
               check_ff <= 1'b1;
               state_ff <= ST_MUL_RR;
            end
            ST_DONE: begin
               if (result_take) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign result.valid = (state_ff == ST_DONE);
   assign result.count = count_ff;

endmodule

@@ rtl/core/mandelbrot_escape_time_top.sv @@
// Top level of the Mandelbrot escape-time counter: registers, core and result register.
//
//   channel   direction  handshake               payload
//   req       in         req_valid / req_stall   req_column[11:0], req_row[11:0]
//   rsp       out        rsp_valid / rsp_stall   rsp_iteration_count[15:0]
//   csr       in         csr_write_enable        csr_index[2:0], csr_write_data[31:0]
//
// One pixel keeps req_stall high from its accepting edge through MUL_CX, MUL_CY, INIT,
// the passes of MUL_RR, MUL_II, MUL_RI and UPDATE (none at limit zero), and DONE; the
// count shows on rsp_valid as that span ends. A full, stalled result register adds its wait.
// Each iteration uses the single 32x32 multiplier for three products (zr*zr, zi*zi,
// zr*zi) and a separate state for the update; the squares also feed the escape test.
// Synchronous reset loads the default view and limit 500 and empties the result register.
// req_stall is high while a pixel is in the core; a stalled result waits in the result
// register while the next transaction is already accepted.
module mandelbrot_escape_time_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [mbet_pkg::INDEX_WIDTH-1:0]      req_column,
   input  logic [mbet_pkg::INDEX_WIDTH-1:0]      req_row,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [mbet_pkg::COUNT_WIDTH-1:0]      rsp_iteration_count,
   input  logic                                  csr_write_enable,
   input  logic [mbet_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [mbet_pkg::COORD_WIDTH-1:0]      csr_write_data
);
   import mbet_pkg::*;

   cfg_type                cfg_ff;
   logic                   rsp_valid_ff;
   logic [COUNT_WIDTH-1:0] rsp_count_ff;
   logic                   busy;
   logic                   start;
   logic                   result_take;
   logic                   slot_free;
   result_type             result;

   // Configuration registers; unknown indexes drop the write
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_origin <= X_ORIGIN_RESET;
         cfg_ff.y_origin <= Y_ORIGIN_RESET;
         cfg_ff.x_step <= X_STEP_RESET;
         cfg_ff.y_step <= Y_STEP_RESET;
         cfg_ff.iteration_limit <= ITER_LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_X_ORIGIN: cfg_ff.x_origin <= csr_write_data;
            CSR_Y_ORIGIN: cfg_ff.y_origin <= csr_write_data;
            CSR_X_STEP: cfg_ff.x_step <= csr_write_data[STEP_WIDTH-1:0];
            CSR_Y_STEP: cfg_ff.y_step <= csr_write_data[STEP_WIDTH-1:0];
            CSR_ITER_LIMIT: cfg_ff.iteration_limit <= csr_write_data[COUNT_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_stall = busy;
   assign start = req_valid && !busy;

   mbet_core u_core (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .column      (req_column),
      .row         (req_row),
      .cfg         (cfg_ff),
      .result_take (result_take),
      .busy        (busy),
      .result      (result)
   );

   // Result register: load when empty or being drained this cycle
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign result_take = result.valid && slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (slot_free) begin
         rsp_valid_ff <= result.valid;
         if (result.valid) begin
            rsp_count_ff <= result.count;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_iteration_count = rsp_count_ff;

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the Mandelbrot escape-time counter.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mbet_pkg::*;

   // Q4.28 scale and escape bound: |z|^2 >= 4 in the squared scale of 2^56.
   localparam int ONE_Q = 1 << FRACTION_BITS;
   localparam longint COORD_MAX = 2147483647;
   localparam longint COORD_MIN = -COORD_MAX - 1;
   localparam logic [63:0] ESCAPE_BOUND = 64'd1 << (2 * FRACTION_BITS + 2);

   // Idle cycles with no transaction before the run is called hung; the limit leaves
   // room for one pixel at limit 65535, which holds the core longest.
   localparam int unsigned WATCHDOG_LIMIT = 800000;
   localparam int unsigned DRAIN_CYCLES = 64;
   localparam int unsigned RANDOM_PHASES = 12;
   localparam int unsigned PIXELS_PER_PHASE = 100;
   localparam int unsigned DEEP_PHASE = 5;

   typedef enum {VIEW_NEAR_SET, VIEW_ANYWHERE, VIEW_FROZEN, VIEW_WIDE} view_mode_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0] column;
      logic [INDEX_WIDTH-1:0] row;
   } pixel_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0] column;
      logic [INDEX_WIDTH-1:0] row;
      logic [COUNT_WIDTH-1:0] count;
   } escape_expect_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [INDEX_WIDTH-1:0]     req_column = '0;
   logic [INDEX_WIDTH-1:0]     req_row = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [COUNT_WIDTH-1:0]     rsp_iteration_count;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [COORD_WIDTH-1:0]     csr_write_data = '0;

   // Shadow of the register file, as the block should hold it.
   cfg_type view;

   pixel_type         pending_pixels[$];
   escape_expect_type expected_counts[$];
   pixel_type         next_pixel;
   escape_expect_type fresh_expect;
   escape_expect_type oldest_expect;

   int unsigned mismatch_count = 0;
   int unsigned idle_cycles = 0;
   int unsigned req_gap = 0;
   int unsigned stall_left = 0;
   logic        quiet_phase = 1'b0;

   mandelbrot_escape_time_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_column          (req_column),
      .req_row             (req_row),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_iteration_count (rsp_iteration_count),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Clamp to the signed 32-bit range of a Q4.28 coordinate.
   function automatic longint clamp_q428(input longint v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return v;
   endfunction

   // Escape-time count of one pixel under the current shadow registers.
   function automatic logic [COUNT_WIDTH-1:0] predict_escape(input logic [INDEX_WIDTH-1:0] column,
                                                             input logic [INDEX_WIDTH-1:0] row);
      longint cr;
      longint ci;
      longint zr;
      longint zi;
      longint next_r;
      longint next_i;
      logic [63:0] magnitude;
      logic [COUNT_WIDTH-1:0] count;
      int unsigned lap;
      cr = clamp_q428(longint'($signed(view.x_origin)) + longint'(column) * longint'(view.x_step));
      ci = clamp_q428(longint'($signed(view.y_origin)) + longint'(row) * longint'(view.y_step));
      zr = cr;
      zi = ci;
      count = '0;
      for (lap = 0; lap < view.iteration_limit; lap++) begin
         // Real part floors by 2^F, imaginary by 2^(F-1) (the factor two of 2*zr*zi).
         next_r = clamp_q428(((zr * zr - zi * zi) >>> FRACTION_BITS) + cr);
         next_i = clamp_q428(((zr * zi) >>> (FRACTION_BITS - 1)) + ci);
         zr = next_r;
         zi = next_i;
         magnitude = $unsigned(zr * zr) + $unsigned(zi * zi);
         // Stop at the first escape and hold the count.
         if (magnitude >= ESCAPE_BOUND) break;
         count++;
      end
      return count;
   endfunction

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int unsigned draw_idle();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (quiet_phase || pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 16);
      return $urandom_range(40, 160);
   endfunction

   task automatic flag_mismatch(input string what);
      $display("%0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   // Write one register for a single cycle and track it in the shadow copy.
   task automatic csr_write(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [31:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_X_ORIGIN: view.x_origin = data;
         CSR_Y_ORIGIN: view.y_origin = data;
         CSR_X_STEP: view.x_step = data[STEP_WIDTH-1:0];
         CSR_Y_STEP: view.y_step = data[STEP_WIDTH-1:0];
         CSR_ITER_LIMIT: view.iteration_limit = data[COUNT_WIDTH-1:0];
         default: ;  // unmapped index: the block drops the write
      endcase
   endtask

   // Hold until every queued pixel is accepted and every count has come back.
   // Sample on the falling edge so the clocked blocks have settled.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_pixels.size() != 0 || req_valid || expected_counts.size() != 0);
   endtask

   task automatic queue_pixel(input logic [INDEX_WIDTH-1:0] column,
                              input logic [INDEX_WIDTH-1:0] row);
      pending_pixels.push_back({column, row});
   endtask

   // Request driver: hold a stalled transaction, otherwise idle out the gap and
   // launch the next pending pixel. Predict each pixel at the edge it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            fresh_expect.column = req_column;
            fresh_expect.row = req_row;
            fresh_expect.count = predict_escape(req_column, req_row);
            expected_counts.push_back(fresh_expect);
         end
         if (!(req_valid && req_stall)) begin
            if (req_gap > 0) begin
               req_gap = req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
               next_pixel = pending_pixels.pop_front();
               req_valid <= 1'b1;
               req_column <= next_pixel.column;
               req_row <= next_pixel.row;
               req_gap = draw_idle();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compare each accepted count with the oldest prediction,
   // then pick the stall for the next cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_counts.size() == 0) begin
               flag_mismatch($sformatf("iteration_count %0d with no pixel outstanding",
                                       rsp_iteration_count));
            end else begin
               oldest_expect = expected_counts.pop_front();
               if (rsp_iteration_count !== oldest_expect.count)
                  flag_mismatch($sformatf("pixel (%0d,%0d): iteration_count %0d, expected %0d",
                                          oldest_expect.column, oldest_expect.row,
                                          rsp_iteration_count, oldest_expect.count));
            end
         end
         if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = draw_idle();
            if (stall_left > 0) begin
               stall_left = stall_left - 1;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Watchdog: end the run if no transaction or register write moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", idle_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus: directed phases, then randomized views.
   initial begin
      int unsigned phase;
      int unsigned n;
      int unsigned spare;
      view_mode_type mode;
      logic [31:0] xo;
      logic [31:0] yo;
      logic [STEP_WIDTH-1:0] xs;
      logic [STEP_WIDTH-1:0] ys;
      logic [COUNT_WIDTH-1:0] lim;

      view.x_origin = X_ORIGIN_RESET;
      view.y_origin = Y_ORIGIN_RESET;
      view.x_step = X_STEP_RESET;
      view.y_step = Y_STEP_RESET;
      view.iteration_limit = ITER_LIMIT_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset view untouched: the corners, two points inside the set (they run
      // the full 500 iterations) and alternating bit patterns.
      queue_pixel(12'd0, 12'd0);
      queue_pixel(12'd4095, 12'd4095);
      queue_pixel(12'd0, 12'd4095);
      queue_pixel(12'd4095, 12'd0);
      queue_pixel(12'd2867, 12'd2048);
      queue_pixel(12'd2048, 12'd2048);
      queue_pixel(12'hAAA, 12'h555);
      queue_pixel(12'h555, 12'hAAA);

      // Limit zero: no iteration is tried, even inside the set. Garbage above
      // the 16 limit bits must be dropped.
      wait_idle();
      csr_write(CSR_ITER_LIMIT, 32'hFFFF_0000);
      queue_pixel(12'd2867, 12'd2048);
      queue_pixel(12'd0, 12'd0);

      // Limit one.
      wait_idle();
      csr_write(CSR_ITER_LIMIT, 32'h0000_0001);
      queue_pixel(12'd2867, 12'd2048);
      queue_pixel(12'd0, 12'd0);

      // Register extremes: c sits at or saturates to the range ends, so every pixel escapes
      // at the first test. Step writes carry a set top bit that must be masked.
      wait_idle();
      csr_write(CSR_X_ORIGIN, 32'h7FFF_FFFF);
      csr_write(CSR_Y_ORIGIN, 32'h8000_0000);
      csr_write(CSR_X_STEP, 32'hFFFF_FFFF);
      csr_write(CSR_Y_STEP, 32'hFFFF_FFFF);
      csr_write(CSR_ITER_LIMIT, 32'h0000_FFFF);
      queue_pixel(12'd0, 12'd0);
      queue_pixel(12'd4095, 12'd4095);
      queue_pixel(12'd4095, 12'd0);

      // c = 0 never escapes: the count must reach the full 65535. Writes to the
      // unmapped indexes land first and must change nothing.
      wait_idle();
      csr_write(CSR_X_ORIGIN, 32'h0);
      csr_write(CSR_Y_ORIGIN, 32'h0);
      csr_write(CSR_X_STEP, 32'h0);
      csr_write(CSR_Y_STEP, 32'h0);
      for (spare = CSR_ITER_LIMIT + 1; spare < (1 << CSR_INDEX_WIDTH); spare++)
         csr_write(CSR_INDEX_WIDTH'(spare), 32'hFFFF_FFFF);
      queue_pixel(12'd4095, 12'd4095);

      // Random views. Most phases keep the limit small so the run stays short;
      // one deep phase covers the set at a limit of several hundred.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         quiet_phase = (phase % 4 == 3);
         mode = view_mode_type'($urandom_range(0, 3));
         if (phase == DEEP_PHASE) mode = VIEW_NEAR_SET;
         case (mode)
            VIEW_NEAR_SET: begin
               xo = $urandom_range(0, ONE_Q) - 2 * ONE_Q;
               yo = $urandom_range(0, ONE_Q) - 3 * (ONE_Q / 2);
               xs = STEP_WIDTH'($urandom_range(1, 1 << 18));
               ys = STEP_WIDTH'($urandom_range(1, 1 << 18));
            end
            VIEW_ANYWHERE: begin
               xo = $urandom;
               yo = $urandom;
               xs = STEP_WIDTH'($urandom);
               ys = STEP_WIDTH'($urandom);
            end
            VIEW_FROZEN: begin
               xo = $urandom_range(0, 2 * ONE_Q) - 2 * ONE_Q;
               yo = $urandom_range(0, 2 * ONE_Q) - ONE_Q;
               xs = '0;
               ys = '0;
            end
            default: begin
               // Wide steps push most pixels out of range and into saturation.
               xo = $urandom_range(0, 2 * ONE_Q) - 2 * ONE_Q;
               yo = $urandom_range(0, 2 * ONE_Q) - 2 * ONE_Q;
               xs = STEP_WIDTH'($urandom_range(1 << 18, 1 << 22));
               ys = STEP_WIDTH'($urandom_range(1 << 18, 1 << 22));
            end
         endcase
         if (phase == DEEP_PHASE) lim = COUNT_WIDTH'($urandom_range(300, 500));
         else if ($urandom_range(0, 3) == 0) lim = COUNT_WIDTH'($urandom_range(1, 255));
         else lim = COUNT_WIDTH'($urandom_range(1, 40));
         csr_write(CSR_X_ORIGIN, xo);
         csr_write(CSR_Y_ORIGIN, yo);
         csr_write(CSR_X_STEP, {1'($urandom), xs});
         csr_write(CSR_Y_STEP, {1'($urandom), ys});
         csr_write(CSR_ITER_LIMIT, {16'($urandom), lim});
         for (n = 0; n < PIXELS_PER_PHASE; n++)
            queue_pixel(12'($urandom), 12'($urandom));
      end

      // Drain, then give a stray result time to show up.
      wait_idle();
      quiet_phase = 1'b0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_counts.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
